/* rtl/core/ffac_pkg.sv */
// shared types, constants and helpers of the first-fit allocator
package ffac_pkg;

    localparam int MAX_FREE  = 32;
    localparam int MAX_USED  = 32;
    localparam int ADDR_BITS = 16;

    localparam int FAW = $clog2(MAX_FREE);
    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int UAW = $clog2(MAX_USED);
    localparam int UCW = $clog2(MAX_USED + 1);

    localparam logic [16:0] CAP_BYTES =
        (ADDR_BITS >= 16) ? 17'd65536 : 17'(1 << ADDR_BITS);

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_NOTALLOC = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] request_size;
        logic [15:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_offset;
        logic [16:0] used_bytes;
    } t_rsp;

    typedef struct packed {
        logic [16:0] off;
        logic [16:0] size;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

    function automatic logic [16:0] arena_of(input logic [16:0] t);
        return (t > CAP_BYTES) ? CAP_BYTES : t;
    endfunction

endpackage

/* rtl/core/ffac_ram.sv */
// simple dual-port ram, one write and one registered read per cycle
module ffac_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 34
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* rtl/core/first_fit_allocator_coalescing_unit.sv */
// top level of the first-fit arena allocator with a coalescing free list
//
// request channel: i_in_valid / o_in_ready carry kind, request_size and
// block_offset; one transfer is one allocate, free, reallocate or none request.
// response channel: o_out_valid / i_out_ready carry status, result_offset
// and used_bytes, exactly one response per request, in order.
// i_cfg_we in IDLE writes total_size and rebuilds the tables to one free segment (none for a zero size).
// timing: each table entry visited takes an address state, then the
// registered read of the ram. allocate scans the free list up to the fit;
// free scans the used list for the block, then the free list for its place,
// plus a read and a write per entry moved when the free list shifts.
// worst case is a reallocate: used scan, free
// scan plus shift, then fit scan plus shift. one request is worked on at a time.
// the response sits in an output register, so the next request is taken
// while it waits; a stalled receiver only holds a finished result in DONE.
// reset (sync, active low) gives a 65536 byte arena, one free segment,
// no allocated blocks and zero used bytes. entry 0 of the free ram is
// written during reset; the used table relies on its count only.
module first_fit_allocator_coalescing_unit
    import ffac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FB_RD, S_FB_CK, S_FP_RD, S_FP_CK, S_MERGE,
        S_SD_RD, S_SD_WR, S_SU_RD, S_SU_WR, S_AM_RD, S_AM_WR,
        S_AS_RD, S_AS_CK, S_DONE
    } t_state;

    t_state      r_state;
    logic [1:0]  r_kind;
    logic [16:0] r_req;
    logic [15:0] r_off;
    logic [FCW-1:0] r_nfree;
    logic [UCW-1:0] r_nused;
    logic [16:0] r_used;
    logic [UCW-1:0] r_b;
    logic [16:0] r_bsize;
    logic [FCW-1:0] r_p;
    logic [FCW-1:0] r_j;
    t_seg        r_lseg;
    t_seg        r_rseg;
    logic        r_has_right;
    logic        r_ret;        // after a drop: go on to remove the used entry
    t_status     r_status;
    logic [15:0] r_where;
    logic        r_out_valid;
    t_rsp        r_out;

    // ram ports
    logic [SEG_W-1:0] free_rd_raw, alloc_rd_raw;
    t_seg             free_rd, alloc_rd;
    logic [FAW-1:0]   fr_addr, fw_addr, fsm_fw_addr;
    logic             fw_en, fsm_fw_en;
    t_seg             fw_data, fsm_fw_data;
    logic [UAW-1:0]   ar_addr, aw_addr;
    logic             aw_en;
    t_seg             aw_data;

    assign free_rd  = t_seg'(free_rd_raw);
    assign alloc_rd = t_seg'(alloc_rd_raw);

    // neighbor tests of the segment being returned
    logic [17:0]    l_end, b_end;
    logic           m_left, m_right;
    logic [FCW-1:0] p_m1, j_p1, j_m1;
    logic [UCW-1:0] nused_m1;
    logic           fits;

    assign l_end    = {1'b0, r_lseg.off} + {1'b0, r_lseg.size};
    assign b_end    = {2'b0, r_off} + {1'b0, r_bsize};
    assign m_left   = (r_p != '0) && (l_end == {2'b0, r_off});
    assign m_right  = r_has_right && (b_end == {1'b0, r_rseg.off});
    assign p_m1     = r_p - FCW'(1);
    assign j_p1     = r_j + FCW'(1);
    assign j_m1     = r_j - FCW'(1);
    assign nused_m1 = r_nused - UCW'(1);
    assign fits     = free_rd.size >= r_req;

    always_comb begin
        fr_addr     = r_p[FAW-1:0];
        fsm_fw_en   = 1'b0;
        fsm_fw_addr = r_p[FAW-1:0];
        fsm_fw_data = free_rd;
        ar_addr     = r_b[UAW-1:0];
        aw_en       = 1'b0;
        aw_addr     = r_b[UAW-1:0];
        aw_data     = alloc_rd;
        case (r_state)
            S_MERGE: begin
                if (m_left && m_right) begin
                    fsm_fw_en   = 1'b1;
                    fsm_fw_addr = p_m1[FAW-1:0];
                    fsm_fw_data = '{off: r_lseg.off,
                                    size: r_lseg.size + r_bsize + r_rseg.size};
                end else if (m_left) begin
                    fsm_fw_en   = 1'b1;
                    fsm_fw_addr = p_m1[FAW-1:0];
                    fsm_fw_data = '{off: r_lseg.off, size: r_lseg.size + r_bsize};
                end else if (m_right) begin
                    fsm_fw_en   = 1'b1;
                    fsm_fw_data = '{off: {1'b0, r_off}, size: r_bsize + r_rseg.size};
                end
            end
            S_SD_RD: fr_addr = j_p1[FAW-1:0];
            S_SD_WR: begin
                fsm_fw_en   = 1'b1;
                fsm_fw_addr = r_j[FAW-1:0];
            end
            S_SU_RD: begin
                if (r_j == r_p) begin
                    fsm_fw_en   = 1'b1;
                    fsm_fw_data = '{off: {1'b0, r_off}, size: r_bsize};
                end else begin
                    fr_addr = j_m1[FAW-1:0];
                end
            end
            S_SU_WR: begin
                fsm_fw_en   = 1'b1;
                fsm_fw_addr = r_j[FAW-1:0];
            end
            S_AM_RD: ar_addr = nused_m1[UAW-1:0];
            S_AM_WR: aw_en = 1'b1;
            S_AS_CK: begin
                if (fits && (r_nused < UCW'(MAX_USED))) begin
                    aw_en   = 1'b1;
                    aw_addr = r_nused[UAW-1:0];
                    aw_data = '{off: free_rd.off, size: r_req};
                    if (free_rd.size != r_req) begin
                        fsm_fw_en   = 1'b1;
                        fsm_fw_data = '{off: free_rd.off + r_req,
                                        size: free_rd.size - r_req};
                    end
                end
            end
            default: ;
        endcase
    end

    // reset and configuration rebuild free entry 0
    always_comb begin
        if (!i_rst_n) begin
            fw_en   = 1'b1;
            fw_addr = '0;
            fw_data = '{off: '0, size: CAP_BYTES};
        end else if (i_cfg_we) begin
            fw_en   = 1'b1;
            fw_addr = '0;
            fw_data = '{off: '0, size: arena_of(i_cfg_data)};
        end else begin
            fw_en   = fsm_fw_en;
            fw_addr = fsm_fw_addr;
            fw_data = fsm_fw_data;
        end
    end

    ffac_ram #(.DEPTH(MAX_FREE), .WIDTH(SEG_W)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fw_en),
        .i_waddr (fw_addr),
        .i_wdata (fw_data),
        .i_raddr (fr_addr),
        .o_rdata (free_rd_raw)
    );

    ffac_ram #(.DEPTH(MAX_USED), .WIDTH(SEG_W)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (aw_en),
        .i_waddr (aw_addr),
        .i_wdata (aw_data),
        .i_raddr (ar_addr),
        .o_rdata (alloc_rd_raw)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nfree     <= FCW'(1);
            r_nused     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // DONE reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_nfree <= (arena_of(i_cfg_data) != '0) ? FCW'(1) : '0;
                        r_nused <= '0;
                        r_used  <= '0;
                    end else if (i_in_valid) begin
                        r_kind  <= i_in_data.kind;
                        r_req   <= i_in_data.request_size;
                        r_off   <= i_in_data.block_offset;
                        r_b     <= '0;
                        r_p     <= '0;
                        r_where <= '0;
                        if (i_in_data.kind == KIND_NONE) begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end else if (i_in_data.kind != KIND_FREE &&
                                     i_in_data.request_size == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_DONE;
                        end else if (i_in_data.kind == KIND_ALLOC) begin
                            r_state <= S_AS_RD;
                        end else begin
                            r_state <= S_FB_RD;
                        end
                    end
                end
                // look up the block in the used table
                S_FB_RD: begin
                    if (r_b >= r_nused) begin
                        r_status <= ST_NOTALLOC;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FB_CK;
                    end
                end
                S_FB_CK: begin
                    if (alloc_rd.off == {1'b0, r_off}) begin
                        r_bsize     <= alloc_rd.size;
                        r_p         <= '0;
                        r_has_right <= 1'b0;
                        r_state     <= S_FP_RD;
                    end else begin
                        r_b     <= r_b + UCW'(1);
                        r_state <= S_FB_RD;
                    end
                end
                // find the insertion point, keep both neighbors
                S_FP_RD: begin
                    if (r_p >= r_nfree) begin
                        r_state <= S_MERGE;
                    end else begin
                        r_state <= S_FP_CK;
                    end
                end
                S_FP_CK: begin
                    if (free_rd.off > {1'b0, r_off}) begin
                        r_rseg      <= free_rd;
                        r_has_right <= 1'b1;
                        r_state     <= S_MERGE;
                    end else begin
                        r_lseg  <= free_rd;
                        r_p     <= r_p + FCW'(1);
                        r_state <= S_FP_RD;
                    end
                end
                S_MERGE: begin
                    if (m_left && m_right) begin
                        r_j     <= r_p;
                        r_ret   <= 1'b1;
                        r_state <= S_SD_RD;
                    end else if (m_left || m_right) begin
                        r_state <= S_AM_RD;
                    end else if (r_nfree >= FCW'(MAX_FREE)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_j     <= r_nfree;
                        r_state <= S_SU_RD;
                    end
                end
                // close the gap at r_j
                S_SD_RD: begin
                    if (j_p1 >= r_nfree) begin
                        r_nfree <= r_nfree - FCW'(1);
                        r_state <= r_ret ? S_AM_RD : S_DONE;
                    end else begin
                        r_state <= S_SD_WR;
                    end
                end
                S_SD_WR: begin
                    r_j     <= j_p1;
                    r_state <= S_SD_RD;
                end
                // open a hole at r_p and fill it
                S_SU_RD: begin
                    if (r_j == r_p) begin
                        r_nfree <= r_nfree + FCW'(1);
                        r_state <= S_AM_RD;
                    end else begin
                        r_state <= S_SU_WR;
                    end
                end
                S_SU_WR: begin
                    r_j     <= j_m1;
                    r_state <= S_SU_RD;
                end
                // last used entry moves into the freed slot
                S_AM_RD: r_state <= S_AM_WR;
                S_AM_WR: begin
                    r_nused <= nused_m1;
                    r_used  <= r_used - r_bsize;
                    if (r_kind == KIND_REALLOC) begin
                        r_p     <= '0;
                        r_state <= S_AS_RD;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                // first-fit scan
                S_AS_RD: begin
                    if (r_p >= r_nfree) begin
                        r_status <= ST_NOFIT;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_AS_CK;
                    end
                end
                S_AS_CK: begin
                    if (fits) begin
                        if (r_nused >= UCW'(MAX_USED)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_nused  <= r_nused + UCW'(1);
                            r_used   <= r_used + r_req;
                            r_where  <= free_rd.off[15:0];
                            r_status <= ST_OK;
                            if (free_rd.size == r_req) begin
                                r_j     <= r_p;
                                r_ret   <= 1'b0;
                                r_state <= S_SD_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        r_p     <= r_p + FCW'(1);
                        r_state <= S_AS_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.status        <= r_status;
                        r_out.result_offset <= (r_status == ST_OK) ? r_where : '0;
                        r_out.used_bytes    <= r_used;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/ffac_checker.sv */
// port-level checks of the allocator, bound to the top level
module ffac_checker
    import ffac_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_req        i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_rsp        o_out_data,
    input logic        i_cfg_we,
    input logic [16:0] i_cfg_data
);

    // held response stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    // a failed request reports no offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.result_offset == '0)
        else $error("offset on failed request");

    // used bytes never exceed the arena
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.used_bytes <= CAP_BYTES)
        else $error("used bytes beyond arena");

    // no response right after reset, and ready for work
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && (o_in_ready || i_cfg_we))
        else $error("bad state after reset");

endmodule

bind first_fit_allocator_coalescing_unit ffac_checker u_ffac_checker (.*);

/* test/tb_alloc_checker.sv */
// checker for the first-fit allocator: predicts each response and compares it
module tb_alloc_checker
    import ffac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_req        i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_rsp        i_out_data,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [16:0] free_off  [MAX_FREE];
    logic [16:0] free_size [MAX_FREE];
    int          free_cnt;
    logic [16:0] blk_off   [MAX_USED];
    logic [16:0] blk_size  [MAX_USED];
    int          blk_cnt;
    logic [16:0] bytes_in_use;
    t_rsp        rsp_queue[$];

    function automatic void rebuild_arena(input logic [16:0] t);
        logic [16:0] a;
        a = (t > 17'd65536) ? 17'd65536 : t;
        free_cnt = 0;
        blk_cnt = 0;
        bytes_in_use = '0;
        if (a != 0) begin
            free_off[0] = '0;
            free_size[0] = a;
            free_cnt = 1;
        end
    endfunction

    function automatic void drop_segment(input int i);
        for (int k = i; k < free_cnt - 1; k++) begin
            free_off[k] = free_off[k+1];
            free_size[k] = free_size[k+1];
        end
        free_cnt--;
    endfunction

    function automatic t_status carve_block(input logic [16:0] req, output logic [15:0] where);
        int i;
        i = 0;
        where = '0;
        while (i < free_cnt && free_size[i] < req) i++;
        if (i >= free_cnt) return ST_NOFIT;
        if (blk_cnt >= MAX_USED) return ST_FULL;
        where = free_off[i][15:0];
        blk_off[blk_cnt] = free_off[i];
        blk_size[blk_cnt] = req;
        blk_cnt++;
        free_off[i] += req;
        free_size[i] -= req;
        if (free_size[i] == 0) drop_segment(i);
        bytes_in_use += req;
        return ST_OK;
    endfunction

    function automatic t_status return_block(input logic [16:0] off);
        int b, p;
        logic [16:0] sz;
        logic left, right;
        b = 0;
        while (b < blk_cnt && blk_off[b] != off) b++;
        if (b >= blk_cnt) return ST_NOTALLOC;
        sz = blk_size[b];
        p = 0;
        while (p < free_cnt && free_off[p] <= off) p++;
        left = p > 0 && (free_off[p-1] + free_size[p-1]) == off;
        right = p < free_cnt && (off + sz) == free_off[p];
        if (!left && !right && free_cnt >= MAX_FREE) return ST_FULL;
        if (left && right) begin
            free_size[p-1] += sz + free_size[p];
            drop_segment(p);
        end else if (left) begin
            free_size[p-1] += sz;
        end else if (right) begin
            free_off[p] = off;
            free_size[p] += sz;
        end else begin
            for (int k = free_cnt; k > p; k--) begin
                free_off[k] = free_off[k-1];
                free_size[k] = free_size[k-1];
            end
            free_off[p] = off;
            free_size[p] = sz;
            free_cnt++;
        end
        blk_off[b] = blk_off[blk_cnt-1];
        blk_size[b] = blk_size[blk_cnt-1];
        blk_cnt--;
        bytes_in_use -= sz;
        return ST_OK;
    endfunction

    function automatic t_rsp predict_response(input t_req r);
        t_rsp o;
        t_status st;
        logic [15:0] where;
        st = ST_OK;
        where = '0;
        case (t_kind'(r.kind))
            KIND_ALLOC: begin
                if (r.request_size == 0) st = ST_ZERO;
                else st = carve_block(r.request_size, where);
            end
            KIND_FREE: st = return_block({1'b0, r.block_offset});
            KIND_REALLOC: begin
                if (r.request_size == 0) begin
                    st = ST_ZERO;
                end else begin
                    st = return_block({1'b0, r.block_offset});
                    if (st == ST_OK) st = carve_block(r.request_size, where);
                end
            end
            default: st = ST_OK;
        endcase
        if (st != ST_OK) where = '0;
        o.status = st;
        o.result_offset = where;
        o.used_bytes = bytes_in_use;
        return o;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rebuild_arena(17'd65536);
            rsp_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) rebuild_arena(i_cfg_data);
            if (i_in_valid && i_in_ready) rsp_queue.push_back(predict_response(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response exp none act %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (exp_rsp !== i_out_data) begin
                        $display("%0t: mismatch exp st=%0d off=%h used=%h act st=%0d off=%h used=%h",
                                 $time, exp_rsp.status, exp_rsp.result_offset,
                                 exp_rsp.used_bytes, i_out_data.status,
                                 i_out_data.result_offset, i_out_data.used_bytes);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
// testbench top for the first-fit allocator: stimulus, idling and verdict
module tb_top;
    import ffac_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_req        in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_rsp        out_data;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    // offsets handed out so far, so frees mostly hit live blocks
    logic [15:0] live_blocks[$];

    always #6 i_clk = ~i_clk;

    first_fit_allocator_coalescing_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    tb_alloc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off) begin
            out_ready <= 1'b0;
        end else begin
            n = gap_len();
            out_ready <= (n == 0);
        end
    end

    // valid stays high into a back-to-back request; a gap or drain() drops it
    task automatic send_request(input t_kind k, input logic [16:0] sz, input logic [15:0] off);
        int n;
        n = gap_len();
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_data <= '{kind: k, request_size: sz, block_offset: off};
        in_valid <= 1'b1;
        // accepted at the edge where valid and ready are both high
        do @(posedge i_clk); while (!in_ready);
        // track live offsets only roughly; misses just yield unknown-offset cases
        if (k == KIND_FREE || k == KIND_REALLOC)
            foreach (live_blocks[i]) if (live_blocks[i] == off) begin
                live_blocks.delete(i);
                break;
            end
    endtask

    // wait until every expected response has been taken, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_arena(input logic [16:0] t);
        drain();
        cfg_data <= t;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        live_blocks.delete();
        @(posedge i_clk);
    endtask

    // pick a free target: usually a live block, sometimes any offset
    function automatic logic [15:0] pick_offset();
        if (live_blocks.size() != 0 && $urandom_range(0, 9) < 8)
            return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        return 16'($urandom());
    endfunction

    function automatic logic [16:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 6) return 17'($urandom());
        if (r < 80) return 17'($urandom_range(1, 64));
        return 17'($urandom_range(1, 4096));
    endfunction

    task automatic random_phase(input int count);
        int r;
        t_kind k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) k = KIND_ALLOC;
            else if (r < 82) k = KIND_FREE;
            else if (r < 97) k = KIND_REALLOC;
            else k = KIND_NONE;
            send_request(k, pick_size(), pick_offset());
            // guess the handed-out offset from the response stream is not needed:
            // record a plausible offset by watching responses below
        end
    endtask

    // learn live offsets from successful responses
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready && out_data.status == ST_OK
            && out_data.result_offset != 0 || (out_valid && out_ready && i_rst_n
            && out_data.status == ST_OK && out_data.used_bytes != 0))
            live_blocks.push_back(out_data.result_offset);
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every kind, each special case
        send_request(KIND_ALLOC, 17'd0, 16'd0);              // zero size
        send_request(KIND_ALLOC, 17'd65537 + 17'd1, 16'd0);  // no fit
        send_request(KIND_ALLOC, 17'd65536, 16'd0);          // whole arena
        send_request(KIND_ALLOC, 17'd1, 16'd0);              // arena exhausted
        send_request(KIND_FREE, 17'd0, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'hFFFF);            // unknown offset
        send_request(KIND_NONE, 17'h1FFFF, 16'hFFFF);        // unused kind
        send_request(KIND_ALLOC, 17'd100, 16'd0);
        send_request(KIND_ALLOC, 17'd200, 16'd0);
        send_request(KIND_ALLOC, 17'd300, 16'd0);
        send_request(KIND_FREE, 17'd0, 16'd100);              // free middle, no neighbor
        send_request(KIND_FREE, 17'd0, 16'd0);                // merge right
        send_request(KIND_REALLOC, 17'd0, 16'd300);           // realloc zero size
        send_request(KIND_REALLOC, 17'd50, 16'd300);          // realloc, merge both sides
        send_request(KIND_REALLOC, 17'h1FFFF, 16'd0);         // realloc cannot fit
        send_request(KIND_REALLOC, 17'd5, 16'd12345);         // realloc unknown offset
        // fill the block table past its limit with one-byte blocks
        for (int i = 0; i < MAX_USED + 1; i++) send_request(KIND_ALLOC, 17'd1, 16'd0);
        // free every other block to fragment the free table
        for (int i = 1; i < MAX_USED; i += 2) send_request(KIND_FREE, 17'd0, 16'(i));

        // zero arena: nothing fits
        write_arena(17'd0);
        send_request(KIND_ALLOC, 17'd1, 16'd0);
        // clamp above the address range
        write_arena(17'h1FFFF);
        send_request(KIND_ALLOC, 17'd65536, 16'd0);
        // smallest useful arena, then fragment the free table
        write_arena(17'd1);
        send_request(KIND_ALLOC, 17'd1, 16'd0);
        write_arena(17'd80);
        for (int i = 0; i < 32; i++) send_request(KIND_ALLOC, 17'd2, 16'd0);
        for (int i = 0; i < 32; i += 2) send_request(KIND_FREE, 17'd0, 16'(2 * i));
        send_request(KIND_FREE, 17'd0, 16'd78);               // no block at this offset
        send_request(KIND_ALLOC, 17'd16, 16'd0);
        for (int i = 2; i < 32; i += 2) send_request(KIND_FREE, 17'd0, 16'(2 * i));

        // small arena: lots of table-full and no-fit traffic
        write_arena(17'd512);
        random_phase(400);

        // pressure: receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join
        // sender pauses until every expected response has come
        drain();

        write_arena(17'd4096);
        random_phase(500);
        write_arena(17'd65536);
        random_phase(700);

        drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
